[src/dmic_pkg.sv]
// Shared types and constants for the direct-mapped instruction cache.
package dmic_pkg;

  // Geometry
  localparam int LINE_COUNT = 256;
  localparam int IDX_W      = $clog2(LINE_COUNT);
  localparam int WORD_W     = 32;
  localparam int LINE_WORDS = 4;
  localparam int LINE_W     = WORD_W * LINE_WORDS;
  localparam int TAG_W      = 25;
  localparam int STALL_W    = 7;
  localparam int PADDR_W    = 3;

  // Address decoding
  localparam logic [31:0] PHYS_MASK  = 32'h1fff_ffff;
  localparam logic [31:0] RAM_LIMIT  = 32'h007f_ffff;
  localparam logic [31:0] BIOS_BASE  = 32'h1fc0_0000;

  // Cycles charged
  localparam logic [STALL_W-1:0] STALL_HIT  = STALL_W'(1);
  localparam logic [STALL_W-1:0] STALL_RAM  = STALL_W'(4 * 4);
  localparam logic [STALL_W-1:0] STALL_BIOS = STALL_W'(4 * 24);
  localparam logic [STALL_W-1:0] STALL_NONE = '0;

  // Register map (byte addresses)
  localparam logic [PADDR_W-1:0] REG_CACHE_ENABLE = PADDR_W'(0);

  // Operation codes
  typedef enum logic [1:0] {
    KIND_FETCH      = 2'd0,
    KIND_READ       = 2'd1,
    KIND_INVALIDATE = 2'd2,
    KIND_NOP        = 2'd3
  } kind_e;

  // Sequencer states
  typedef enum logic {
    ST_IDLE,
    ST_LOOKUP
  } state_e;

endpackage

[src/direct_mapped_icache.sv]
// Direct-mapped instruction cache: tag and line RAMs with a lookup/write-back sequencer.
// Output: after the tag and line RAM reads are registered, the result is registered at the output;
//   it waits in the lookup state only while the output register holds a result not yet taken.
// Acceptance: a new transaction is taken only in the idle state, after the synchronous read of
//   the tag and line RAMs and the write-back on the same line in the lookup state.
// The output register lets the next transaction be taken while a result waits.
// Reset: valid and line-written flags clear at once (no sweep); cache_enable resets to 1.
module direct_mapped_icache (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // input channel
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [1:0]                      kind_i,
  input  logic [31:0]                     address_i,
  input  logic [31:0]                     fill_word_0_i,
  input  logic [31:0]                     fill_word_1_i,
  input  logic [31:0]                     fill_word_2_i,
  input  logic [31:0]                     fill_word_3_i,
  // output channel
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [31:0]                     data_word_o,
  output logic [dmic_pkg::STALL_W-1:0]    stall_cycles_o,
  output logic                            hit_o,
  output logic                            refilled_o,
  // configuration port
  input  logic                            psel_i,
  input  logic                            penable_i,
  input  logic                            pwrite_i,
  input  logic [dmic_pkg::PADDR_W-1:0]    paddr_i,
  input  logic [31:0]                     pwdata_i,
  output logic [31:0]                     prdata_o,
  output logic                            pready_o
);
  import dmic_pkg::*;

  // Configuration register
  logic cache_en_q;
  logic cfg_we;

  assign pready_o = 1'b1;
  assign cfg_we   = psel_i && penable_i && pwrite_i && (paddr_i == REG_CACHE_ENABLE);
  assign prdata_o = (paddr_i == REG_CACHE_ENABLE) ? {31'b0, cache_en_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cache_en_q <= 1'b1;
    end else if (cfg_we) begin
      cache_en_q <= pwdata_i[0];
    end
  end

  // Sequencer
  state_e state_q, state_d;
  logic   in_fire;
  logic   complete;
  logic   out_valid_q, out_valid_d;

  assign in_fire  = in_valid_i && in_ready_o;
  assign complete = (state_q == ST_LOOKUP) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_fire) state_d = ST_LOOKUP;
      ST_LOOKUP: if (complete) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE:   in_ready_o = 1'b1;
      ST_LOOKUP: in_ready_o = 1'b0;
      default:   in_ready_o = 1'b0;
    endcase
  end

  // Captured transaction
  kind_e             kind_q;
  logic [IDX_W-1:0]  line_q;
  logic [TAG_W-1:0]  tag_q;
  logic [1:0]        sel_q;
  logic              is_ram_q;
  logic              is_bios_q;
  logic [LINE_W-1:0] fill_q;
  logic [31:0]       masked_in;

  assign masked_in = address_i & PHYS_MASK;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      kind_q    <= kind_e'(kind_i);
      line_q    <= address_i[4 +: IDX_W];
      tag_q     <= masked_in[4 +: TAG_W];
      sel_q     <= address_i[3:2];
      is_ram_q  <= (masked_in <= RAM_LIMIT);
      is_bios_q <= (masked_in >= BIOS_BASE);
      fill_q    <= {fill_word_3_i, fill_word_2_i, fill_word_1_i, fill_word_0_i};
    end
  end

  // Tag and line RAMs, registered read
  logic [TAG_W-1:0]  tag_mem  [LINE_COUNT];
  logic [LINE_W-1:0] word_mem [LINE_COUNT];
  logic [TAG_W-1:0]  tag_rd_q;
  logic [LINE_W-1:0] words_rd_q;
  logic              tag_we;
  logic              words_we;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      tag_rd_q   <= tag_mem[address_i[4 +: IDX_W]];
      words_rd_q <= word_mem[address_i[4 +: IDX_W]];
    end
    if (tag_we) begin
      tag_mem[line_q] <= tag_q;
    end
    if (words_we) begin
      word_mem[line_q] <= fill_q;
    end
  end

  // Per-line flags: valid, and words loaded since reset (unloaded lines read zero)
  logic [LINE_COUNT-1:0] valid_q;
  logic [LINE_COUNT-1:0] written_q;
  logic                  set_valid;
  logic                  clr_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= '0;
      written_q <= '0;
    end else begin
      if (set_valid) valid_q[line_q] <= 1'b1;
      if (clr_valid) valid_q[line_q] <= 1'b0;
      if (words_we)  written_q[line_q] <= 1'b1;
    end
  end

  // Lookup and update
  logic              is_fetch;
  logic              lookup_hit;
  logic              do_refill;
  logic [LINE_W-1:0] stored_line;
  logic [LINE_W-1:0] result_line;
  logic [31:0]       sel_word;

  assign is_fetch    = (kind_q == KIND_FETCH);
  assign lookup_hit  = cache_en_q && valid_q[line_q] && (tag_rd_q == tag_q);
  assign do_refill   = is_fetch && !lookup_hit && (is_ram_q || is_bios_q);
  assign stored_line = written_q[line_q] ? words_rd_q : '0;
  assign result_line = do_refill ? fill_q : stored_line;
  assign sel_word    = result_line[{sel_q, 5'b0} +: WORD_W];

  assign tag_we    = complete && is_fetch && !lookup_hit;
  assign set_valid = tag_we;
  assign words_we  = complete && do_refill;
  assign clr_valid = complete && (kind_q == KIND_INVALIDATE);

  // Output register
  logic [31:0]        data_q;
  logic [STALL_W-1:0] stall_q;
  logic               hit_q;
  logic               refilled_q;

  always_comb begin
    out_valid_d = out_valid_q;
    if (complete) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (complete) begin
      hit_q      <= is_fetch && lookup_hit;
      refilled_q <= do_refill;
      unique case (kind_q)
        KIND_FETCH: begin
          data_q <= sel_word;
          if (lookup_hit)         stall_q <= STALL_HIT;
          else if (!do_refill)    stall_q <= STALL_NONE;
          else if (is_ram_q)      stall_q <= STALL_RAM;
          else                    stall_q <= STALL_BIOS;
        end
        KIND_READ: begin
          data_q  <= sel_word;
          stall_q <= STALL_NONE;
        end
        default: begin
          data_q  <= '0;
          stall_q <= STALL_NONE;
        end
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign data_word_o    = data_q;
  assign stall_cycles_o = stall_q;
  assign hit_o          = hit_q;
  assign refilled_o     = refilled_q;

  // Checks
  a_fire_to_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == ST_LOOKUP))
    else $error("accepted transaction did not enter lookup");

  a_hit_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && hit_o) |-> (stall_cycles_o == STALL_HIT) && !refilled_o)
    else $error("hit result with wrong stall or refill flag");

  a_refill_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && refilled_o) |->
      (stall_cycles_o == STALL_RAM) || (stall_cycles_o == STALL_BIOS))
    else $error("refill result with wrong stall count");

  a_refill_marks_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    words_we |=> written_q[$past(line_q)] && valid_q[$past(line_q)])
    else $error("refilled line not marked valid and written");

endmodule
